@@ rtl/kmeans_3d_cluster_engine_defines.svh @@
// Assertion macros used by the engine's top-level RTL.
`ifndef KMEANS_3D_CLUSTER_ENGINE_DEFINES_SVH
`define KMEANS_3D_CLUSTER_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define KC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmeans engine check failed");
// Next-cycle implication.
`define KC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmeans engine check failed");
`else
`define KC_ASSERT_SAME(label, clk, rst, ante, cons)
`define KC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/kc_pkg.sv @@
package kc_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_POINTS   = 1024;
  localparam int COORD_BITS   = 12;

  localparam int CID_W  = $clog2(MAX_CLUSTERS);
  localparam int KCNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = PIDX_W + 1;
  localparam int SUM_W  = COORD_BITS + PIDX_W + 1;
  localparam int NUM_W  = SUM_W + CID_W;
  localparam int OFF_W  = CID_W + 3;
  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int SLOT_W = 4;
  localparam int PASS_W = 6;
  localparam int STAB_W = 4;
  localparam int CFG_W  = 6;

  localparam logic [PASS_W-1:0] PASS_CAP = PASS_W'(62);

  typedef enum logic [1:0] {
    MODE_LOAD_CENTROID = 2'd0,
    MODE_ADD_POINT     = 2'd1,
    MODE_RUN           = 2'd2
  } mode_t;

  localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd0;
  localparam logic [1:0] CFG_MAX_PASSES    = 2'd1;
  localparam logic [1:0] CFG_STABLE_PASSES = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_CLEAR,
    ST_ASSIGN,
    ST_DRAIN,
    ST_SCAN,
    ST_LAUNCH,
    ST_WAIT,
    ST_ROT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic signed [SUM_W-1:0]      sx;
    logic signed [SUM_W-1:0]      sy;
    logic signed [SUM_W-1:0]      sz;
    logic [CNT_W-1:0]             cnt;
  } cell_state_t;

  typedef struct packed {
    logic                         valid;
    logic [PIDX_W-1:0]            pidx;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic [DIST_W-1:0]            dsq;
    logic [CID_W-1:0]             best;
  } token_t;

  typedef struct packed {
    logic                         load_en;
    logic [SLOT_W-1:0]            load_slot;
    logic signed [COORD_BITS-1:0] load_x;
    logic signed [COORD_BITS-1:0] load_y;
    logic signed [COORD_BITS-1:0] load_z;
    logic                         clear;
    logic                         shift;
    logic                         acc_en;
    logic [CID_W-1:0]             acc_id;
    logic signed [COORD_BITS-1:0] acc_x;
    logic signed [COORD_BITS-1:0] acc_y;
    logic signed [COORD_BITS-1:0] acc_z;
  } cell_ctl_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [NUM_W-1:0] v
  );
    logic signed [NUM_W-1:0] hi;
    logic signed [NUM_W-1:0] lo;
    hi = signed'(NUM_W'(2 ** (COORD_BITS - 1) - 1));
    lo = -hi - signed'(NUM_W'(1));
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

@@ rtl/kc_ram.sv @@
module kc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/kc_div.sv @@
module kc_div
  import kc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [CNT_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [NUM_W-1:0]  q;
  logic [CNT_W-1:0]  den_r;
  logic              neg;
  logic [CNT_W:0]    rem_shift;
  logic              ge;

  always_comb begin
    rem_shift = {rem, q[NUM_W-1]};
    ge        = rem_shift >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      q     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg   <= num[NUM_W-1];
      rem   <= '0;
      den_r <= den;
      steps <= STEP_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (ge) begin
        rem <= CNT_W'(rem_shift - {1'b0, den_r});
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[CNT_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? -signed'(q) : signed'(q);

endmodule

@@ rtl/kc_cell.sv @@
module kc_cell
  import kc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CID_W-1:0]  idx,
  input  logic [KCNT_W-1:0] k,
  input  cell_ctl_t         ctl,
  input  token_t            tok_in,
  output token_t            tok_out,
  input  cell_state_t       feed,
  output cell_state_t       st
);

  logic signed [COORD_BITS:0]   ex, ey, ez;
  logic signed [DIST_W-1:0]     sqx, sqy, sqz;
  logic [DIST_W-1:0]            sqd;
  logic                         active;
  logic                         take;
  logic                         load_hit;

  always_comb begin
    ex   = (COORD_BITS+1)'(st.cx) - (COORD_BITS+1)'(tok_in.px);
    ey   = (COORD_BITS+1)'(st.cy) - (COORD_BITS+1)'(tok_in.py);
    ez   = (COORD_BITS+1)'(st.cz) - (COORD_BITS+1)'(tok_in.pz);
    sqx  = ex * ex;
    sqy  = ey * ey;
    sqz  = ez * ez;
    sqd  = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
    active = KCNT_W'(idx) < k;
    // Strict compare keeps the lower index on ties.
    take = active && ((idx == '0) || (sqd < tok_in.dsq));
    load_hit = ctl.load_en &&
               ({{SLOT_W{1'b0}}, idx} == {{CID_W{1'b0}}, ctl.load_slot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.pidx <= tok_in.pidx;
    tok_out.px   <= tok_in.px;
    tok_out.py   <= tok_in.py;
    tok_out.pz   <= tok_in.pz;
    tok_out.dsq  <= take ? sqd : tok_in.dsq;
    tok_out.best <= take ? idx : tok_in.best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (load_hit) begin
      st.cx <= ctl.load_x;
      st.cy <= ctl.load_y;
      st.cz <= ctl.load_z;
    end else if (ctl.clear) begin
      st.sx  <= '0;
      st.sy  <= '0;
      st.sz  <= '0;
      st.cnt <= '0;
    end else if (ctl.shift) begin
      st <= feed;
    end else if (ctl.acc_en && ctl.acc_id == idx) begin
      st.sx  <= st.sx + SUM_W'(ctl.acc_x);
      st.sy  <= st.sy + SUM_W'(ctl.acc_y);
      st.sz  <= st.sz + SUM_W'(ctl.acc_z);
      st.cnt <= st.cnt + CNT_W'(1);
    end
  end

endmodule

@@ rtl/kmeans_3d_cluster_engine.sv @@
// Lloyd k-means engine for signed 3-D points. Each start transaction is taken
// while busy is low: mode 0 loads a centroid slot, mode 1 appends a point to
// the point memory, and mode 2 runs the clustering, during which busy stays
// high. A run first streams every point through a chain of MAX_CLUSTERS
// distance cells (one point per cycle, with a clear step before and a drain
// step after), then rotates the cells once to find the largest cluster, then
// rotates again computing each new mean with one shared serial divider, three
// divisions of NUM_W = 27 bit numerators per cluster in use and one rotation
// step per unused cell. That sequence repeats for every pass. At the end the
// engine emits one result per cluster in use, cluster_id ascending, on
// consecutive cycles with result_strobe high, final_flag set on the last one.
// The receiver cannot stall, so every strobe cycle must be captured. A run
// with no points loaded gives a single result with status 1 in the cycle right
// after the start transaction.
// Configuration writes are taken at any time, cfg_ready is always high; write
// only between runs.
`include "kmeans_3d_cluster_engine_defines.svh"

module kmeans_3d_cluster_engine
  import kc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [SLOT_W-1:0]            centroid_slot,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic                         result_strobe,
  output logic [CID_W-1:0]             cluster_id,
  output logic signed [COORD_BITS-1:0] mean_x,
  output logic signed [COORD_BITS-1:0] mean_y,
  output logic signed [COORD_BITS-1:0] mean_z,
  output logic [PASS_W-1:0]            pass_total,
  output logic                         status,
  output logic                         final_flag,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam logic [CID_W-1:0] LAST_CELL = CID_W'(MAX_CLUSTERS - 1);

  state_t state, state_next;

  // Configuration registers.
  logic [4:0]        cluster_count;
  logic [PASS_W-1:0] max_passes;
  logic [STAB_W-1:0] stable_passes;

  // Run control.
  logic [CNT_W-1:0]  point_total;
  logic [CNT_W-1:0]  p;
  logic [KCNT_W-1:0] k;
  logic [PASS_W-1:0] pass;
  logic [PASS_W-1:0] limit;
  logic [STAB_W-1:0] stable;
  logic [STAB_W-1:0] stable_next;
  logic              changed;
  logic              moved;
  logic              empty;
  logic              moved_now;
  logic              empty_now;
  logic              fin;
  logic [CID_W-1:0]  r;
  logic [1:0]        axis;
  logic [1:0]        m3;
  logic [2:0]        m5;
  logic              r_in_k;
  logic              r_next_in_k;

  // Largest-cluster snapshot and new centroid under construction.
  logic [CNT_W-1:0]             big_cnt;
  logic signed [SUM_W-1:0]      big_sx, big_sy, big_sz;
  logic signed [COORD_BITS-1:0] nx, ny, nz;

  // Chain and memories.
  cell_ctl_t         ctl;
  cell_state_t       cst [MAX_CLUSTERS];
  cell_state_t       feed_head;
  token_t            tok [MAX_CLUSTERS+1];
  token_t            sa;
  logic              v0;
  logic [PIDX_W-1:0] pidx0;
  logic [3*COORD_BITS-1:0] pq;
  logic [CID_W-1:0]  arow;
  logic [MAX_CLUSTERS-1:0] vbits;
  logic              chain_busy;
  logic              accept;
  logic              point_we;
  logic [5:0]        k_raw;

  // Divider interface.
  logic                    div_start;
  logic                    div_done;
  logic signed [NUM_W-1:0] div_num;
  logic [CNT_W-1:0]        div_den;
  logic signed [NUM_W-1:0] div_quo;
  logic signed [SUM_W-1:0] hsum, bsum;
  logic [OFF_W-1:0]        off;
  logic [OFF_W+CNT_W-1:0]  prod;
  logic signed [COORD_BITS-1:0] sat_q;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign point_we  = accept && mode == MODE_ADD_POINT &&
                     point_total < CNT_W'(MAX_POINTS);
  assign limit     = (max_passes > PASS_CAP) ? PASS_CAP : max_passes;
  assign r_in_k      = KCNT_W'(r) < k;
  assign r_next_in_k = (KCNT_W'(r) + KCNT_W'(1)) < k;
  assign k_raw       = {1'b0, cluster_count};

  kc_ram #(.WIDTH(3*COORD_BITS), .DEPTH(MAX_POINTS)) u_points (
    .clk   (clk),
    .we    (point_we),
    .waddr (point_total[PIDX_W-1:0]),
    .wdata ({coord_x, coord_y, coord_z}),
    .raddr (p[PIDX_W-1:0]),
    .rdata (pq)
  );

  // Assignments of the previous pass; the first pass always counts as changed.
  kc_ram #(.WIDTH(CID_W), .DEPTH(MAX_POINTS)) u_assign (
    .clk   (clk),
    .we    (sa.valid),
    .waddr (sa.pidx),
    .wdata (sa.best),
    .raddr (tok[MAX_CLUSTERS].pidx),
    .rdata (arow)
  );

  always_comb begin
    tok[0].valid = v0;
    tok[0].pidx  = pidx0;
    tok[0].px    = pq[3*COORD_BITS-1:2*COORD_BITS];
    tok[0].py    = pq[2*COORD_BITS-1:COORD_BITS];
    tok[0].pz    = pq[COORD_BITS-1:0];
    tok[0].dsq   = '0;
    tok[0].best  = '0;
  end

  for (genvar j = 0; j < MAX_CLUSTERS; j++) begin : g_cell
    cell_state_t feed_j;
    if (j == MAX_CLUSTERS - 1) begin : g_tail
      assign feed_j = feed_head;
    end else begin : g_mid
      assign feed_j = cst[j+1];
    end
    kc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (CID_W'(j)),
      .k       (k),
      .ctl     (ctl),
      .tok_in  (tok[j]),
      .tok_out (tok[j+1]),
      .feed    (feed_j),
      .st      (cst[j])
    );
    assign vbits[j] = tok[j+1].valid;
  end

  assign chain_busy = v0 || (|vbits) || sa.valid;

  kc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Numerator and divisor for the current axis of the head cell.
  always_comb begin
    case (axis)
      2'd1: begin
        hsum = cst[0].sy;
        bsum = big_sy;
        off  = OFF_W'(m3);
      end
      2'd2: begin
        hsum = cst[0].sz;
        bsum = big_sz;
        off  = OFF_W'(m5);
      end
      default: begin
        hsum = cst[0].sx;
        bsum = big_sx;
        off  = OFF_W'(r);
      end
    endcase
    prod = off * big_cnt;
    if (cst[0].cnt != '0) begin
      div_num = NUM_W'(hsum);
      div_den = cst[0].cnt;
    end else begin
      // Empty cluster: shifted mean of the largest one.
      div_num = NUM_W'(bsum) - NUM_W'(prod);
      div_den = big_cnt;
    end
    sat_q = sat_coord(div_quo);
  end

  // Pass bookkeeping evaluated on the last rotation step.
  always_comb begin
    moved_now = moved || (r_in_k &&
                (nx != cst[0].cx || ny != cst[0].cy || nz != cst[0].cz));
    empty_now = empty || (r_in_k && cst[0].cnt == '0);
    fin = 1'b0;
    if (changed) begin
      stable_next = stable_passes;
    end else if (stable != '0) begin
      stable_next = stable - STAB_W'(1);
      fin = stable == STAB_W'(1);
    end else begin
      stable_next = stable;
    end
    if (empty_now) begin
      fin = 1'b0;
    end
    if (!moved_now || pass >= limit) begin
      fin = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_RUN) begin
          state_next = (point_total == '0) ? ST_ERR : ST_CLEAR;
        end
      end
      ST_ERR:    state_next = ST_IDLE;
      ST_CLEAR:  state_next = ST_ASSIGN;
      ST_ASSIGN: begin
        if (p == point_total - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!chain_busy) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (r == LAST_CELL) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          state_next = (axis == 2'd2) ? ST_ROT : ST_LAUNCH;
        end
      end
      ST_ROT: begin
        if (r == LAST_CELL) begin
          state_next = fin ? ST_EMIT : ST_CLEAR;
        end else begin
          state_next = r_next_in_k ? ST_LAUNCH : ST_ROT;
        end
      end
      ST_EMIT: begin
        if (r == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Chain control and result ports.
  always_comb begin
    ctl.load_en   = accept && mode == MODE_LOAD_CENTROID;
    ctl.load_slot = centroid_slot;
    ctl.load_x    = coord_x;
    ctl.load_y    = coord_y;
    ctl.load_z    = coord_z;
    ctl.clear     = state == ST_CLEAR;
    ctl.shift     = state == ST_SCAN || state == ST_ROT || state == ST_EMIT;
    ctl.acc_en    = sa.valid;
    ctl.acc_id    = sa.best;
    ctl.acc_x     = sa.px;
    ctl.acc_y     = sa.py;
    ctl.acc_z     = sa.pz;
    div_start     = state == ST_LAUNCH;
    feed_head     = cst[0];
    if (state == ST_ROT && r_in_k) begin
      feed_head.cx = nx;
      feed_head.cy = ny;
      feed_head.cz = nz;
    end
    result_strobe = 1'b0;
    cluster_id    = '0;
    mean_x        = '0;
    mean_y        = '0;
    mean_z        = '0;
    pass_total    = '0;
    status        = 1'b0;
    final_flag    = 1'b0;
    case (state)
      ST_ERR: begin
        result_strobe = 1'b1;
        status        = 1'b1;
        final_flag    = 1'b1;
      end
      ST_EMIT: begin
        result_strobe = r_in_k;
        cluster_id    = r;
        mean_x        = cst[0].cx;
        mean_y        = cst[0].cy;
        mean_z        = cst[0].cz;
        pass_total    = pass;
        final_flag    = r_in_k && !r_next_in_k;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cluster_count <= 5'd16;
      max_passes    <= PASS_W'(50);
      stable_passes <= STAB_W'(10);
      point_total   <= '0;
      v0            <= 1'b0;
      p             <= '0;
      k             <= '0;
      pass          <= '0;
      stable        <= '0;
      changed       <= 1'b0;
      moved         <= 1'b0;
      empty         <= 1'b0;
      r             <= '0;
      axis          <= '0;
      m3            <= '0;
      m5            <= '0;
    end else begin
      state    <= state_next;
      v0       <= state == ST_ASSIGN;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLUSTER_COUNT: cluster_count <= cfg_data[4:0];
          CFG_MAX_PASSES:    max_passes    <= cfg_data[PASS_W-1:0];
          CFG_STABLE_PASSES: stable_passes <= cfg_data[STAB_W-1:0];
          default: begin
          end
        endcase
      end
      if (point_we) begin
        point_total <= point_total + CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          pass   <= '0;
          stable <= stable_passes;
          r      <= '0;
          // Clamp k into the supported range.
          if (k_raw < 6'd2) begin
            k <= KCNT_W'(2);
          end else if (k_raw > 6'(MAX_CLUSTERS)) begin
            k <= KCNT_W'(MAX_CLUSTERS);
          end else begin
            k <= KCNT_W'(k_raw);
          end
        end
        ST_CLEAR: begin
          p       <= '0;
          changed <= pass == '0;
        end
        ST_ASSIGN, ST_DRAIN: begin
          if (state == ST_ASSIGN) begin
            p <= p + CNT_W'(1);
          end
          if (sa.valid && arow != sa.best) begin
            changed <= 1'b1;
          end
          r <= '0;
        end
        ST_SCAN: begin
          r     <= (r == LAST_CELL) ? '0 : r + CID_W'(1);
          axis  <= '0;
          m3    <= '0;
          m5    <= '0;
          moved <= 1'b0;
          empty <= 1'b0;
        end
        ST_WAIT: begin
          if (div_done) begin
            axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
          end
        end
        ST_ROT: begin
          moved <= moved_now;
          empty <= empty_now;
          m3    <= (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
          m5    <= (m5 == 3'd4) ? 3'd0 : m5 + 3'd1;
          if (r == LAST_CELL) begin
            r      <= '0;
            pass   <= pass + PASS_W'(1);
            stable <= stable_next;
          end else begin
            r <= r + CID_W'(1);
          end
        end
        ST_EMIT: begin
          r <= (r == LAST_CELL) ? '0 : r + CID_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
    end else begin
      sa.valid <= tok[MAX_CLUSTERS].valid;
    end
    pidx0   <= p[PIDX_W-1:0];
    sa.pidx <= tok[MAX_CLUSTERS].pidx;
    sa.px   <= tok[MAX_CLUSTERS].px;
    sa.py   <= tok[MAX_CLUSTERS].py;
    sa.pz   <= tok[MAX_CLUSTERS].pz;
    sa.dsq  <= tok[MAX_CLUSTERS].dsq;
    sa.best <= tok[MAX_CLUSTERS].best;
    if (state == ST_DRAIN) begin
      big_cnt <= '0;
    end else if (state == ST_SCAN && r_in_k && cst[0].cnt > big_cnt) begin
      // Keep the first cluster with the most members.
      big_cnt <= cst[0].cnt;
      big_sx  <= cst[0].sx;
      big_sy  <= cst[0].sy;
      big_sz  <= cst[0].sz;
    end
    if (state == ST_WAIT && div_done) begin
      case (axis)
        2'd1:    ny <= sat_q;
        2'd2:    nz <= sat_q;
        default: nx <= sat_q;
      endcase
    end
  end

  `KC_ASSERT_SAME(a_err_is_final, clk, rst, result_strobe && status, final_flag)
  `KC_ASSERT_SAME(a_result_while_busy, clk, rst, result_strobe, busy)
  `KC_ASSERT_NEXT(a_run_goes_busy, clk, rst, accept && mode == MODE_RUN, busy)
  `KC_ASSERT_NEXT(a_final_ends_burst, clk, rst, result_strobe && final_flag, !result_strobe)

endmodule

@@ sim/tb_kmeans_3d_cluster_engine.sv @@
`timescale 1ns / 1ps

import kc_pkg::*;

// One centroid report as the engine should emit it.
typedef struct {
  logic [3:0]         cid;
  logic signed [11:0] mx;
  logic signed [11:0] my;
  logic signed [11:0] mz;
  logic [5:0]         npass;
  logic               err;
  logic               last;
} centroid_report_t;

class kmeans_scoreboard;
  int                 cent[16][3];
  int                 pts[1024][3];
  int                 asg[1024];
  int unsigned        npts;
  logic [4:0]         k_reg;
  logic [5:0]         pass_reg;
  logic [3:0]         stab_reg;
  centroid_report_t   reports_due[$];
  int                 errors;
  int                 runs;
  int                 checked;

  function new();
    foreach (cent[i, c]) cent[i][c] = 0;
    npts = 0;
    k_reg = 5'd16;
    pass_reg = 6'd50;
    stab_reg = 4'd10;
    errors = 0;
    runs = 0;
    checked = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [5:0] data);
    if (idx == CFG_CLUSTER_COUNT) k_reg = data[4:0];
    else if (idx == CFG_MAX_PASSES) pass_reg = data;
    else if (idx == CFG_STABLE_PASSES) stab_reg = data[3:0];
  endfunction

  function automatic int clip(longint v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return int'(v);
  endfunction

  // Truncating mean with an offset per member, saturated.
  function automatic int shifted_mean(longint s, int n, int off);
    longint num;
    num = s - longint'(off) * longint'(n);
    return clip(num / longint'(n));
  endfunction

  function automatic int k_eff();
    if (k_reg < 2) return 2;
    if (k_reg > 16) return 16;
    return k_reg;
  endfunction

  function automatic int closest(int p);
    int      best;
    longint  bestd;
    longint  d;
    longint  e;
    best = 0;
    bestd = 0;
    for (int j = 0; j < k_eff(); j++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        e = longint'(cent[j][c]) - longint'(pts[p][c]);
        d += e * e;
      end
      if (j == 0 || d < bestd) begin
        bestd = d;
        best = j;
      end
    end
    return best;
  endfunction

  function automatic void cluster_run();
    int      k;
    int      lim;
    int      pass;
    int      stable;
    int      a;
    int      big;
    int      bigcnt;
    int      nv[3];
    bit      done;
    bit      changed;
    bit      moved;
    bit      empty;
    longint  sums[16][3];
    int      cnt[16];
    centroid_report_t r;
    k = k_eff();
    lim = (pass_reg > 62) ? 62 : pass_reg;
    for (int i = 0; i < npts; i++) asg[i] = 16;
    stable = stab_reg;
    pass = 0;
    done = 0;
    while (!done) begin
      changed = 0;
      moved = 0;
      empty = 0;
      for (int i = 0; i < npts; i++) begin
        a = closest(i);
        if (a != asg[i]) changed = 1;
        asg[i] = a;
      end
      if (changed) stable = stab_reg;
      else if (stable > 0) begin
        stable--;
        if (stable == 0) done = 1;
      end
      for (int i = 0; i < 16; i++) begin
        cnt[i] = 0;
        for (int c = 0; c < 3; c++) sums[i][c] = 0;
      end
      for (int i = 0; i < npts; i++) begin
        for (int c = 0; c < 3; c++) sums[asg[i]][c] += pts[i][c];
        cnt[asg[i]]++;
      end
      big = 0;
      bigcnt = 0;
      for (int i = 0; i < k; i++) begin
        if (cnt[i] > bigcnt) begin
          bigcnt = cnt[i];
          big = i;
        end
      end
      for (int i = 0; i < k; i++) begin
        if (cnt[i] != 0) begin
          for (int c = 0; c < 3; c++) nv[c] = shifted_mean(sums[i][c], cnt[i], 0);
        end else begin
          // Empty cluster: reseed from largest cluster's mean, offsets i, i % 3, i % 5.
          empty = 1;
          nv[0] = shifted_mean(sums[big][0], bigcnt, i);
          nv[1] = shifted_mean(sums[big][1], bigcnt, i % 3);
          nv[2] = shifted_mean(sums[big][2], bigcnt, i % 5);
        end
        for (int c = 0; c < 3; c++) begin
          if (nv[c] != cent[i][c]) moved = 1;
          cent[i][c] = nv[c];
        end
      end
      if (empty) done = 0;
      if (!moved) done = 1;
      if (pass >= lim) done = 1;
      pass++;
    end
    for (int i = 0; i < k; i++) begin
      r.cid = i[3:0];
      r.mx = cent[i][0][11:0];
      r.my = cent[i][1][11:0];
      r.mz = cent[i][2][11:0];
      r.npass = pass[5:0];
      r.err = 1'b0;
      r.last = (i + 1 == k);
      reports_due.push_back(r);
    end
  endfunction

  // Note one accepted input transaction and queue what it produces.
  function void note_item(logic [1:0] m, logic [3:0] slot, logic signed [11:0] x,
                          logic signed [11:0] y, logic signed [11:0] z);
    centroid_report_t r;
    if (m == MODE_LOAD_CENTROID) begin
      cent[slot][0] = x;
      cent[slot][1] = y;
      cent[slot][2] = z;
    end else if (m == MODE_ADD_POINT) begin
      if (npts < 1024) begin
        pts[npts][0] = x;
        pts[npts][1] = y;
        pts[npts][2] = z;
        npts++;
      end
    end else if (m == MODE_RUN) begin
      runs++;
      if (npts == 0) begin
        r = '{cid: 4'd0, mx: 12'sd0, my: 12'sd0, mz: 12'sd0, npass: 6'd0,
              err: 1'b1, last: 1'b1};
        reports_due.push_back(r);
      end else begin
        cluster_run();
      end
    end
  endfunction

  function void check_report(centroid_report_t got);
    centroid_report_t want;
    checked++;
    if (reports_due.size() == 0) begin
      $display("%0t: unexpected result cluster_id=%0d", $time, got.cid);
      errors++;
      return;
    end
    want = reports_due.pop_front();
    if (got.cid !== want.cid || got.mx !== want.mx || got.my !== want.my ||
        got.mz !== want.mz || got.npass !== want.npass || got.err !== want.err ||
        got.last !== want.last) begin
      $display("%0t: mismatch expected id=%0d x=%0d y=%0d z=%0d pass=%0d st=%0d fin=%0d",
               $time, want.cid, want.mx, want.my, want.mz, want.npass, want.err,
               want.last);
      $display("%0t:          actual   id=%0d x=%0d y=%0d z=%0d pass=%0d st=%0d fin=%0d",
               $time, got.cid, got.mx, got.my, got.mz, got.npass, got.err, got.last);
      errors++;
    end
  endfunction
endclass

module tb_kmeans_3d_cluster_engine;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            mode = MODE_LOAD_CENTROID;
  logic [SLOT_W-1:0]     centroid_slot = '0;
  logic signed [11:0]    coord_x = '0;
  logic signed [11:0]    coord_y = '0;
  logic signed [11:0]    coord_z = '0;
  logic                  result_strobe;
  logic [CID_W-1:0]      cluster_id;
  logic signed [11:0]    mean_x;
  logic signed [11:0]    mean_y;
  logic signed [11:0]    mean_z;
  logic [PASS_W-1:0]     pass_total;
  logic                  status;
  logic                  final_flag;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = CFG_CLUSTER_COUNT;
  logic [CFG_W-1:0]      cfg_data = '0;

  kmeans_scoreboard sb = new();
  int               idle_pct;
  int               hubs[4][3];

  kmeans_3d_cluster_engine DUT (.*);

  always #5 clk = ~clk;

  // Capture every strobed result; the engine never waits for us.
  always @(posedge clk) begin
    centroid_report_t got;
    if (!rst && result_strobe) begin
      got.cid = cluster_id;
      got.mx = mean_x;
      got.my = mean_y;
      got.mz = mean_z;
      got.npass = pass_total;
      got.err = status;
      got.last = final_flag;
      sb.check_report(got);
    end
  end

  // Hold one transaction until the engine takes it, then maybe idle a bit.
  task automatic send_item(logic [1:0] m, logic [3:0] slot, logic signed [11:0] x,
                           logic signed [11:0] y, logic signed [11:0] z);
    start <= 1'b1;
    mode <= m;
    centroid_slot <= slot;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(m, slot, x, y, z);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop start and wait for every queued report and for the engine to go idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.reports_due.size() != 0 || busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinates: mostly near one of a few hubs, sometimes anywhere.
  function automatic logic signed [11:0] pick_coord(int axis);
    int v;
    if ($urandom_range(99) < 25) return 12'($urandom);
    v = hubs[$urandom_range(3)][axis] + $signed($urandom_range(0, 60)) - 30;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[11:0];
  endfunction

  task automatic random_phase(int n_items);
    int r;
    foreach (hubs[h, c]) hubs[h][c] = $signed($urandom_range(0, 4000)) - 2000;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 30)
        send_item(MODE_LOAD_CENTROID, 4'($urandom), pick_coord(0), pick_coord(1),
                  pick_coord(2));
      else if (r < 93)
        send_item(MODE_ADD_POINT, 4'($urandom), pick_coord(0), pick_coord(1),
                  pick_coord(2));
      else if (r < 97)
        send_item(MODE_UNUSED, 4'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom));
      else
        send_item(MODE_RUN, 4'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    end
    send_item(MODE_RUN, 4'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    settle();
  endtask

  initial begin
    // Register settings per phase: k, pass limit, stability; raw values past range too.
    int settings[8][3] = '{'{2, 1, 1}, '{31, 8, 0}, '{0, 62, 15}, '{5, 63, 3},
                           '{17, 20, 2}, '{1, 5, 0}, '{16, 12, 1}, '{8, 40, 7}};
    int idles[3] = '{0, 47, 30};
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: run with nothing loaded, ignored mode, extreme loads and points.
    send_item(MODE_RUN, 4'd0, 12'sd0, 12'sd0, 12'sd0);
    send_item(MODE_UNUSED, 4'hF, 12'h7FF, 12'h800, 12'hFFF);
    send_item(MODE_LOAD_CENTROID, 4'd0, -12'sd2048, -12'sd2048, -12'sd2048);
    send_item(MODE_LOAD_CENTROID, 4'd15, 12'sd2047, 12'sd2047, 12'sd2047);
    send_item(MODE_LOAD_CENTROID, 4'd1, 12'sd0, 12'sd0, 12'sd0);
    send_item(MODE_ADD_POINT, 4'd0, -12'sd2048, -12'sd2048, -12'sd2048);
    send_item(MODE_ADD_POINT, 4'd0, 12'sd2047, 12'sd2047, 12'sd2047);
    send_item(MODE_ADD_POINT, 4'd0, -12'sd2048, 12'sd2047, -12'sd1);
    send_item(MODE_ADD_POINT, 4'd0, -12'sd2047, -12'sd2048, -12'sd2046);
    // Equidistant from slots 0 and 1: lowest index should win the tie.
    send_item(MODE_ADD_POINT, 4'd0, -12'sd1024, -12'sd1024, -12'sd1024);
    send_item(MODE_ADD_POINT, 4'd0, 12'sd0, 12'sd0, 12'sd0);
    send_item(MODE_ADD_POINT, 4'd0, 12'sd1, -12'sd1, 12'sd2);
    send_item(MODE_RUN, 4'd0, 12'sd0, 12'sd0, 12'sd0);
    settle();
    // The run above, default k of 16 with few points, left empty clusters; now k of 2.
    write_reg(CFG_CLUSTER_COUNT, 6'd2);
    write_reg(CFG_MAX_PASSES, 6'd0);
    write_reg(CFG_STABLE_PASSES, 6'd0);
    send_item(MODE_RUN, 4'd0, 12'sd0, 12'sd0, 12'sd0);
    settle();

    // Random phases, each with its own register setting and one of three idle rates.
    foreach (settings[p]) begin
      idle_pct = idles[p % 3];
      write_reg(CFG_CLUSTER_COUNT, 6'(settings[p][0]));
      write_reg(CFG_MAX_PASSES, 6'(settings[p][1]));
      write_reg(CFG_STABLE_PASSES, 6'(settings[p][2]));
      random_phase(26);
    end
    repeat (40) @(posedge clk);

    $display("Covered %0d clustering runs, %0d centroid reports checked, %0d points held.",
             sb.runs, sb.checked, sb.npts);
    if (sb.errors == 0 && sb.reports_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/kc_pkg.sv
rtl/kc_ram.sv
rtl/kc_div.sv
rtl/kc_cell.sv
rtl/kmeans_3d_cluster_engine.sv
sim/tb_kmeans_3d_cluster_engine.sv
